[hw/rtl/quaternion_vector_rotation_core_macros.svh]
// assertion macros used by the quaternion rotation checker
`ifndef QUATERNION_VECTOR_ROTATION_CORE_MACROS_SVH
`define QUATERNION_VECTOR_ROTATION_CORE_MACROS_SVH

// implication checked on every edge outside reset
`define QVR_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequence expected after the antecedent, delayed by the dly argument
`define QVR_ASSERT_DELAY(lbl, ante, dly, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(dly) (cons)) \
        else $error(msg);

`endif

[hw/rtl/qvr_pkg.sv]
// shared types and constants of the quaternion vector rotation core
`default_nettype none

package qvr_pkg;

    localparam int COMP_W       = 16;
    localparam int QUAT_W       = 16;
    localparam int FRAC_SHIFT   = 28;
    localparam int PROD_W       = 2 * QUAT_W;
    localparam int PSUM_W       = PROD_W + 1;
    localparam int MAT_W        = PROD_W + 2;
    localparam int MV_W         = MAT_W + COMP_W;
    localparam int SUM_W        = MV_W + 2;
    localparam int CFG_IDX_W    = 8;
    localparam int CFG_DATA_W   = QUAT_W;
    localparam int PIPE_LATENCY = 6;

    localparam logic [CFG_IDX_W-1:0] REG_QUAT_W = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_QUAT_X = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_QUAT_Y = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_QUAT_Z = CFG_IDX_W'(3);

    // 1.0 in q2.14
    localparam logic [QUAT_W-1:0] QUAT_ONE = QUAT_W'(1) << (QUAT_W - 2);

    localparam logic signed [COMP_W-1:0] COMP_MAX = {1'b0, {(COMP_W - 1){1'b1}}};
    localparam logic signed [COMP_W-1:0] COMP_MIN = {1'b1, {(COMP_W - 1){1'b0}}};

    typedef struct packed {
        logic signed [COMP_W-1:0] vec_x;
        logic signed [COMP_W-1:0] vec_y;
        logic signed [COMP_W-1:0] vec_z;
    } vec_t;

    typedef struct packed {
        logic signed [COMP_W-1:0] out_x;
        logic signed [COMP_W-1:0] out_y;
        logic signed [COMP_W-1:0] out_z;
        logic                     saturated;
    } res_t;

    typedef struct packed {
        logic signed [QUAT_W-1:0] w;
        logic signed [QUAT_W-1:0] x;
        logic signed [QUAT_W-1:0] y;
        logic signed [QUAT_W-1:0] z;
    } quat_t;

    typedef struct packed {
        logic signed [MAT_W-1:0] m00;
        logic signed [MAT_W-1:0] m01;
        logic signed [MAT_W-1:0] m02;
        logic signed [MAT_W-1:0] m10;
        logic signed [MAT_W-1:0] m11;
        logic signed [MAT_W-1:0] m12;
        logic signed [MAT_W-1:0] m20;
        logic signed [MAT_W-1:0] m21;
        logic signed [MAT_W-1:0] m22;
    } mat_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] row_x;
        logic signed [SUM_W-1:0] row_y;
        logic signed [SUM_W-1:0] row_z;
    } sum_t;

endpackage

`default_nettype wire

[hw/rtl/qvr_matrix.sv]
// two-stage rotation matrix build from the quaternion of each request
`default_nettype none

module qvr_matrix (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire qvr_pkg::quat_t in_quat,
    input  wire qvr_pkg::vec_t  in_vec,
    output logic               out_valid,
    output qvr_pkg::mat_t      out_mat,
    output qvr_pkg::vec_t      out_vec
);

    typedef struct packed {
        logic signed [qvr_pkg::PROD_W-1:0] ww;
        logic signed [qvr_pkg::PROD_W-1:0] xx;
        logic signed [qvr_pkg::PROD_W-1:0] yy;
        logic signed [qvr_pkg::PROD_W-1:0] zz;
        logic signed [qvr_pkg::PROD_W-1:0] xy;
        logic signed [qvr_pkg::PROD_W-1:0] wz;
        logic signed [qvr_pkg::PROD_W-1:0] xz;
        logic signed [qvr_pkg::PROD_W-1:0] wy;
        logic signed [qvr_pkg::PROD_W-1:0] yz;
        logic signed [qvr_pkg::PROD_W-1:0] wx;
    } prod_t;

    logic          prod_valid_reg;
    prod_t         prod_reg;
    prod_t         prod_next;
    qvr_pkg::vec_t prod_vec_reg;

    logic          mat_valid_reg;
    qvr_pkg::mat_t mat_reg;
    qvr_pkg::mat_t mat_next;
    qvr_pkg::vec_t mat_vec_reg;

    logic signed [qvr_pkg::PSUM_W-1:0] xy_m_wz;
    logic signed [qvr_pkg::PSUM_W-1:0] xz_p_wy;
    logic signed [qvr_pkg::PSUM_W-1:0] xy_p_wz;
    logic signed [qvr_pkg::PSUM_W-1:0] yz_m_wx;
    logic signed [qvr_pkg::PSUM_W-1:0] xz_m_wy;
    logic signed [qvr_pkg::PSUM_W-1:0] yz_p_wx;

    always_comb
    begin
        prod_next.ww = in_quat.w * in_quat.w;
        prod_next.xx = in_quat.x * in_quat.x;
        prod_next.yy = in_quat.y * in_quat.y;
        prod_next.zz = in_quat.z * in_quat.z;
        prod_next.xy = in_quat.x * in_quat.y;
        prod_next.wz = in_quat.w * in_quat.z;
        prod_next.xz = in_quat.x * in_quat.z;
        prod_next.wy = in_quat.w * in_quat.y;
        prod_next.yz = in_quat.y * in_quat.z;
        prod_next.wx = in_quat.w * in_quat.x;
    end

    always_comb
    begin
        xy_m_wz = qvr_pkg::PSUM_W'(prod_reg.xy) - qvr_pkg::PSUM_W'(prod_reg.wz);
        xz_p_wy = qvr_pkg::PSUM_W'(prod_reg.xz) + qvr_pkg::PSUM_W'(prod_reg.wy);
        xy_p_wz = qvr_pkg::PSUM_W'(prod_reg.xy) + qvr_pkg::PSUM_W'(prod_reg.wz);
        yz_m_wx = qvr_pkg::PSUM_W'(prod_reg.yz) - qvr_pkg::PSUM_W'(prod_reg.wx);
        xz_m_wy = qvr_pkg::PSUM_W'(prod_reg.xz) - qvr_pkg::PSUM_W'(prod_reg.wy);
        yz_p_wx = qvr_pkg::PSUM_W'(prod_reg.yz) + qvr_pkg::PSUM_W'(prod_reg.wx);

        mat_next.m00 = qvr_pkg::MAT_W'(prod_reg.ww) + qvr_pkg::MAT_W'(prod_reg.xx)
                     - qvr_pkg::MAT_W'(prod_reg.yy) - qvr_pkg::MAT_W'(prod_reg.zz);
        mat_next.m11 = qvr_pkg::MAT_W'(prod_reg.ww) - qvr_pkg::MAT_W'(prod_reg.xx)
                     + qvr_pkg::MAT_W'(prod_reg.yy) - qvr_pkg::MAT_W'(prod_reg.zz);
        mat_next.m22 = qvr_pkg::MAT_W'(prod_reg.ww) - qvr_pkg::MAT_W'(prod_reg.xx)
                     - qvr_pkg::MAT_W'(prod_reg.yy) + qvr_pkg::MAT_W'(prod_reg.zz);

        // off-diagonal terms carry the factor of two as a left shift
        mat_next.m01 = {xy_m_wz, 1'b0};
        mat_next.m02 = {xz_p_wy, 1'b0};
        mat_next.m10 = {xy_p_wz, 1'b0};
        mat_next.m12 = {yz_m_wx, 1'b0};
        mat_next.m20 = {xz_m_wy, 1'b0};
        mat_next.m21 = {yz_p_wx, 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            mat_valid_reg  <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= in_valid;
            mat_valid_reg  <= prod_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg     <= prod_next;
        prod_vec_reg <= in_vec;
        mat_reg      <= mat_next;
        mat_vec_reg  <= prod_vec_reg;
    end

    assign out_valid = mat_valid_reg;
    assign out_mat   = mat_reg;
    assign out_vec   = mat_vec_reg;

endmodule

`default_nettype wire

[hw/rtl/qvr_mac.sv]
// two-stage matrix times vector: nine products, then three row sums
`default_nettype none

module qvr_mac (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire qvr_pkg::mat_t in_mat,
    input  wire qvr_pkg::vec_t in_vec,
    output logic               out_valid,
    output qvr_pkg::sum_t      out_sum
);

    typedef struct packed {
        logic signed [qvr_pkg::MV_W-1:0] p00;
        logic signed [qvr_pkg::MV_W-1:0] p01;
        logic signed [qvr_pkg::MV_W-1:0] p02;
        logic signed [qvr_pkg::MV_W-1:0] p10;
        logic signed [qvr_pkg::MV_W-1:0] p11;
        logic signed [qvr_pkg::MV_W-1:0] p12;
        logic signed [qvr_pkg::MV_W-1:0] p20;
        logic signed [qvr_pkg::MV_W-1:0] p21;
        logic signed [qvr_pkg::MV_W-1:0] p22;
    } mv_t;

    logic          mv_valid_reg;
    mv_t           mv_reg;
    mv_t           mv_next;
    logic          sum_valid_reg;
    qvr_pkg::sum_t sum_reg;
    qvr_pkg::sum_t sum_next;

    always_comb
    begin
        mv_next.p00 = in_mat.m00 * in_vec.vec_x;
        mv_next.p01 = in_mat.m01 * in_vec.vec_y;
        mv_next.p02 = in_mat.m02 * in_vec.vec_z;
        mv_next.p10 = in_mat.m10 * in_vec.vec_x;
        mv_next.p11 = in_mat.m11 * in_vec.vec_y;
        mv_next.p12 = in_mat.m12 * in_vec.vec_z;
        mv_next.p20 = in_mat.m20 * in_vec.vec_x;
        mv_next.p21 = in_mat.m21 * in_vec.vec_y;
        mv_next.p22 = in_mat.m22 * in_vec.vec_z;
    end

    always_comb
    begin
        sum_next.row_x = qvr_pkg::SUM_W'(mv_reg.p00) + qvr_pkg::SUM_W'(mv_reg.p01)
                       + qvr_pkg::SUM_W'(mv_reg.p02);
        sum_next.row_y = qvr_pkg::SUM_W'(mv_reg.p10) + qvr_pkg::SUM_W'(mv_reg.p11)
                       + qvr_pkg::SUM_W'(mv_reg.p12);
        sum_next.row_z = qvr_pkg::SUM_W'(mv_reg.p20) + qvr_pkg::SUM_W'(mv_reg.p21)
                       + qvr_pkg::SUM_W'(mv_reg.p22);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mv_valid_reg  <= 1'b0;
            sum_valid_reg <= 1'b0;
        end
        else
        begin
            mv_valid_reg  <= in_valid;
            sum_valid_reg <= mv_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mv_reg  <= mv_next;
        sum_reg <= sum_next;
    end

    assign out_valid = sum_valid_reg;
    assign out_sum   = sum_reg;

endmodule

`default_nettype wire

[hw/rtl/qvr_round.sv]
// rounding, saturation and the result register
`default_nettype none

module qvr_round (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire qvr_pkg::sum_t in_sum,
    output logic               out_valid,
    output qvr_pkg::res_t      out_res
);

    localparam logic signed [qvr_pkg::SUM_W-1:0] ROUND_BIAS =
        qvr_pkg::SUM_W'(1) <<< (qvr_pkg::FRAC_SHIFT - 1);
    localparam logic signed [qvr_pkg::SUM_W-1:0] SAT_HI = qvr_pkg::SUM_W'(qvr_pkg::COMP_MAX);
    localparam logic signed [qvr_pkg::SUM_W-1:0] SAT_LO = qvr_pkg::SUM_W'(qvr_pkg::COMP_MIN);

    // returns {clipped, value}; round half toward plus infinity
    function automatic logic [qvr_pkg::COMP_W:0] round_sat(
        input logic signed [qvr_pkg::SUM_W-1:0] acc
    );
        logic signed [qvr_pkg::SUM_W-1:0] biased;
        logic signed [qvr_pkg::SUM_W-1:0] scaled;
        logic [qvr_pkg::COMP_W:0]         ret;
        biased = acc + ROUND_BIAS;
        scaled = biased >>> qvr_pkg::FRAC_SHIFT;
        if (scaled > SAT_HI)
            ret = {1'b1, qvr_pkg::COMP_MAX};
        else if (scaled < SAT_LO)
            ret = {1'b1, qvr_pkg::COMP_MIN};
        else
            ret = {1'b0, scaled[qvr_pkg::COMP_W-1:0]};
        return ret;
    endfunction

    logic                      res_valid_reg;
    qvr_pkg::res_t             res_reg;
    qvr_pkg::res_t             res_next;
    logic [qvr_pkg::COMP_W:0]  rx;
    logic [qvr_pkg::COMP_W:0]  ry;
    logic [qvr_pkg::COMP_W:0]  rz;

    always_comb
    begin
        rx = round_sat(in_sum.row_x);
        ry = round_sat(in_sum.row_y);
        rz = round_sat(in_sum.row_z);
        res_next.out_x     = rx[qvr_pkg::COMP_W-1:0];
        res_next.out_y     = ry[qvr_pkg::COMP_W-1:0];
        res_next.out_z     = rz[qvr_pkg::COMP_W-1:0];
        res_next.saturated = rx[qvr_pkg::COMP_W] | ry[qvr_pkg::COMP_W] | rz[qvr_pkg::COMP_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else
            res_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign out_valid = res_valid_reg;
    assign out_res   = res_reg;

endmodule

`default_nettype wire

[hw/rtl/quaternion_vector_rotation_core.sv]
// top level of the quaternion vector rotation core
`default_nettype none

// Rotates one 3-D vector per clock by the quaternion held in registers 0..3
// (w, x, y, z, signed q2.14, reset to identity). A request is taken at every
// edge where start is high; busy is always low, so a new vector may be issued
// every cycle. Each result shows on result with done high for exactly one
// cycle, in request order. The pipeline has six register stages: input
// capture, quaternion products, matrix sums, matrix-vector products, row
// sums, and rounding with saturation. The receiver cannot stall and the
// pipeline never holds. A register write takes effect for a request issued
// on any later edge.
module quaternion_vector_rotation_core (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire qvr_pkg::vec_t                    vec,
    output logic                                  done,
    output qvr_pkg::res_t                         result,
    input  wire logic                             cfg_we,
    input  wire logic [qvr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [qvr_pkg::CFG_DATA_W-1:0]   cfg_data
);

    qvr_pkg::quat_t quat_reg;
    qvr_pkg::quat_t quat_next;

    logic           in_valid_reg;
    qvr_pkg::vec_t  in_vec_reg;
    qvr_pkg::quat_t in_quat_reg;

    logic           mat_valid;
    qvr_pkg::mat_t  mat;
    qvr_pkg::vec_t  mat_vec;
    logic           sum_valid;
    qvr_pkg::sum_t  sum;

    assign busy = 1'b0;

    always_comb
    begin
        quat_next = quat_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                qvr_pkg::REG_QUAT_W: quat_next.w = cfg_data;
                qvr_pkg::REG_QUAT_X: quat_next.x = cfg_data;
                qvr_pkg::REG_QUAT_Y: quat_next.y = cfg_data;
                qvr_pkg::REG_QUAT_Z: quat_next.z = cfg_data;
                default:             quat_next   = quat_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quat_reg.w   <= qvr_pkg::QUAT_ONE;
            quat_reg.x   <= '0;
            quat_reg.y   <= '0;
            quat_reg.z   <= '0;
            in_valid_reg <= 1'b0;
        end
        else
        begin
            quat_reg     <= quat_next;
            in_valid_reg <= start && !busy;
        end
    end

    // the quaternion travels with each request through the matrix stages
    always_ff @(posedge clk)
    begin
        in_vec_reg  <= vec;
        in_quat_reg <= quat_reg;
    end

    qvr_matrix u_matrix (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid_reg),
        .in_quat   (in_quat_reg),
        .in_vec    (in_vec_reg),
        .out_valid (mat_valid),
        .out_mat   (mat),
        .out_vec   (mat_vec)
    );

    qvr_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mat_valid),
        .in_mat    (mat),
        .in_vec    (mat_vec),
        .out_valid (sum_valid),
        .out_sum   (sum)
    );

    qvr_round u_round (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sum_valid),
        .in_sum    (sum),
        .out_valid (done),
        .out_res   (result)
    );

endmodule

`default_nettype wire

[hw/rtl/qvr_checker.sv]
// port-level checker for the quaternion vector rotation core, with its bind
`default_nettype none

`include "quaternion_vector_rotation_core_macros.svh"

module qvr_checker (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          start,
    input wire logic          busy,
    input wire qvr_pkg::vec_t vec,
    input wire logic          done,
    input wire qvr_pkg::res_t result
);

    localparam int LAT = qvr_pkg::PIPE_LATENCY;

    logic req;
    logic sat_seen;
    logic on_rail;
    logic zero_in;
    logic zero_out;

    assign req      = start && !busy;
    assign sat_seen = done && result.saturated;
    assign on_rail  = (result.out_x == qvr_pkg::COMP_MAX) || (result.out_x == qvr_pkg::COMP_MIN)
                   || (result.out_y == qvr_pkg::COMP_MAX) || (result.out_y == qvr_pkg::COMP_MIN)
                   || (result.out_z == qvr_pkg::COMP_MAX) || (result.out_z == qvr_pkg::COMP_MIN);
    assign zero_in  = (vec == '0);
    assign zero_out = (result == '0);

    // every request comes back with done high
    `QVR_ASSERT_DELAY(a_req_done, req, LAT, done, "request lost")

    // no result without a request
    `QVR_ASSERT_IMPL(a_done_req, done, $past(req, LAT), "spurious result")

    // clipping flag only with a component on a rail
    `QVR_ASSERT_IMPL(a_sat_rail, sat_seen, on_rail, "saturation flag without clipped component")

    // a zero vector rotates to zero under any quaternion
    `QVR_ASSERT_DELAY(a_zero_vec, req && zero_in, LAT, done && zero_out, "zero vector not kept")

endmodule

bind quaternion_vector_rotation_core qvr_checker u_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .vec    (vec),
    .done   (done),
    .result (result)
);

`default_nettype wire
